[rtl/multiset_count_table_macros.svh]
// ----------------------------------------------------------------------------
// multiset_count_table_macros
// assertion macros shared by the multiset count table
// ----------------------------------------------------------------------------
`ifndef MULTISET_COUNT_TABLE_MACROS_SVH
`define MULTISET_COUNT_TABLE_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define MCT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, disabled in reset
`define MCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mct_pkg.sv]
// ----------------------------------------------------------------------------
// mct_pkg
// types and constants of the multiset count table
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int DISTINCT_MAX = 64;
  localparam int IDX_W        = $clog2(DISTINCT_MAX);
  localparam int NUM_W        = $clog2(DISTINCT_MAX + 1);
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 16;
  localparam int ENTRY_W      = VAL_W + CNT_W;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 48;

  localparam logic [CNT_W-1:0] TOTAL_LIMIT = 16'hFFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 16'hFFFF;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic load;
    logic issue;
    logic take_match;
    logic exec;
    logic shift;
    logic shift_end;
    logic resp;
  } mct_cmd_t;

  typedef struct packed {
    logic match;
    logic more;
    logic pend;
    logic need_shift;
    logic out_free;
  } mct_sts_t;

endpackage

[rtl/mct_ram.sv]
// ----------------------------------------------------------------------------
// mct_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/mct_ctrl.sv]
// ----------------------------------------------------------------------------
// mct_ctrl
// sequencer: accept, table scan, execute, compaction shift, respond
// ----------------------------------------------------------------------------
module mct_ctrl import mct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  mct_sts_t sts,
  output mct_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.match) begin
          cmd.take_match = 1'b1;
          state_nxt      = S_EXEC;
        end else if (sts.more) begin
          cmd.issue = 1'b1;
        end else if (!sts.pend) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_shift ? S_SHIFT : S_RESP;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        cmd.issue = sts.more;
        if (!sts.more && !sts.pend) begin
          cmd.shift_end = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/mct_datapath.sv]
// ----------------------------------------------------------------------------
// mct_datapath
// table ram, scan compare, counters, command execution and result register
// ----------------------------------------------------------------------------
module mct_datapath import mct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  mct_cmd_t              cmd,
  output mct_sts_t              sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [1:0]       cmd_r, cmd_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [NUM_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [NUM_W-1:0] distinct_r, distinct_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [NUM_W-1:0]   slot_next;

  mct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DISTINCT_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign slot_next = {1'b0, slot_r} + NUM_W'(1);

  always_comb begin
    sts.match      = rd_vld_r && (ram_rdata[ENTRY_W-1:CNT_W] == val_r);
    sts.more       = idx_r < distinct_r;
    sts.pend       = rd_vld_r;
    sts.need_shift = (cmd_r == CMD_REMOVE) && found_r && (cnt_r <= CNT_W'(1));
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = cmd.issue;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    distinct_nxt  = distinct_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_r;
    ram_wdata     = {val_r, cnt_r};

    if (cmd.load) begin
      cmd_nxt    = in_tdata[1:0];
      val_nxt    = in_tdata[33:2];
      idx_nxt    = '0;
      found_nxt  = 1'b0;
      cnt_nxt    = '0;
      status_nxt = ST_DONE;
    end

    if (cmd.issue) begin
      rd_idx_nxt = idx_r[IDX_W-1:0];
      idx_nxt    = idx_r + NUM_W'(1);
    end

    if (cmd.take_match) begin
      found_nxt = 1'b1;
      slot_nxt  = rd_idx_r;
      cnt_nxt   = ram_rdata[CNT_W-1:0];
    end

    if (cmd.exec) begin
      unique case (cmd_r)
        CMD_ADD: begin
          if (total_r >= TOTAL_LIMIT) begin
            status_nxt = ST_FULL;
          end else if (found_r) begin
            if (cnt_r == COUNT_MAX) begin
              status_nxt = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_r;
              ram_wdata = {val_r, cnt_r + CNT_W'(1)};
              cnt_nxt   = cnt_r + CNT_W'(1);
              total_nxt = total_r + CNT_W'(1);
            end
          end else if (distinct_r >= NUM_W'(DISTINCT_MAX)) begin
            status_nxt = ST_FULL;
          end else begin
            ram_we       = 1'b1;
            ram_waddr    = distinct_r[IDX_W-1:0];
            ram_wdata    = {val_r, CNT_W'(1)};
            distinct_nxt = distinct_r + NUM_W'(1);
            total_nxt    = total_r + CNT_W'(1);
            cnt_nxt      = CNT_W'(1);
            found_nxt    = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (!found_r) begin
            status_nxt = ST_ABSENT;
          end else begin
            if (total_r != '0) begin
              total_nxt = total_r - CNT_W'(1);
            end
            if (cnt_r <= CNT_W'(1)) begin
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              idx_nxt   = slot_next;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_r;
              ram_wdata = {val_r, cnt_r - CNT_W'(1)};
              cnt_nxt   = cnt_r - CNT_W'(1);
            end
          end
        end
        default: begin
          if (!found_r) begin
            status_nxt = ST_ABSENT;
          end
        end
      endcase
    end

    // compaction: entry read last cycle moves down one place
    if (cmd.shift && rd_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx_r - IDX_W'(1);
      ram_wdata = ram_rdata;
    end

    if (cmd.shift_end) begin
      distinct_nxt = distinct_r - NUM_W'(1);
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.resp) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'd0, distinct_r, total_r, cnt_r,
                       found_r && (cnt_r != '0), status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      distinct_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= rd_vld_nxt;
      distinct_r  <= distinct_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/multiset_count_table.sv]
// ----------------------------------------------------------------------------
// multiset_count_table
// latency from accept to result grows with the matching slot on a match, or with n
//   when absent, n = distinct values; freeing an entry adds a shift of each later entry
// one command at a time: the next command is taken in the cycle after its result is
//   registered; a stalled result holds the following one back
// reset clears the counters and control; the table needs no clearing
// ----------------------------------------------------------------------------
`include "multiset_count_table_macros.svh"

module multiset_count_table import mct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // command[1:0], value[33:2], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], present[2], copies[18:3], total_copies[34:19],
  // distinct_used[41:35], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  mct_cmd_t cmd;
  mct_sts_t sts;

  logic             out_present;
  logic [CNT_W-1:0] out_copies;
  logic [NUM_W-1:0] out_distinct;

  mct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mct_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign out_present  = out_tdata[2];
  assign out_copies   = out_tdata[18:3];
  assign out_distinct = out_tdata[41:35];

  `MCT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "taken while busy")
  `MCT_ASSERT_SAME(a_resp_needs_room, cmd.resp, sts.out_free, "result overwritten")
  `MCT_ASSERT_SAME(a_distinct_max, out_tvalid, out_distinct <= 7'(DISTINCT_MAX), "overflow")
  `MCT_ASSERT_SAME(a_present_copies, out_tvalid && out_present, out_copies != '0, "zero copies")

endmodule
